// File: hw/rtl/crcs_pkg.sv
// ---------------------------------------------------------------------------
// crcs_pkg
// Types, polynomial table and byte-fold function for the CRC-32 stream unit.
// ---------------------------------------------------------------------------
package crcs_pkg;

	typedef logic [7:0]  data_byte_t;
	typedef logic [31:0] crc_t;
	typedef logic [1:0]  poly_sel_t;

	localparam poly_sel_t POLY_CRC32  = 2'd0;
	localparam poly_sel_t POLY_CRC32C = 2'd1;
	localparam poly_sel_t POLY_CRC32K = 2'd2;
	localparam poly_sel_t POLY_CRC32Q = 2'd3;

	localparam int unsigned NUM_POLYS = 4;
	localparam int unsigned BYTE_BITS = 8;
	localparam int unsigned CRC_BITS  = 32;

	localparam crc_t POLY_TABLE [NUM_POLYS] = '{
		32'h04C1_1DB7,
		32'h1EDC_6F41,
		32'h741B_8CD7,
		32'h8141_41AB
	};

	function automatic crc_t poly_lookup(input poly_sel_t sel);
		crc_t p;
		case (sel)
			POLY_CRC32:  p = POLY_TABLE[0];
			POLY_CRC32C: p = POLY_TABLE[1];
			POLY_CRC32K: p = POLY_TABLE[2];
			POLY_CRC32Q: p = POLY_TABLE[3];
			default:     p = POLY_TABLE[0];
		endcase
		return p;
	endfunction

	// MSB-first, non-reflected fold of one byte: eight shift/xor steps
	function automatic crc_t crc_fold(input crc_t rem, input data_byte_t data,
		input crc_t poly);
		crc_t r;
		r = rem ^ {data, {(CRC_BITS - BYTE_BITS){1'b0}}};
		for (int i = 0; i < BYTE_BITS; i++) begin
			if (r[CRC_BITS-1]) begin
				r = {r[CRC_BITS-2:0], 1'b0} ^ poly;
			end else begin
				r = {r[CRC_BITS-2:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/crcs_msg_if.sv
// ---------------------------------------------------------------------------
// crcs_msg_if
// Message byte channel: one byte per transaction, with end-of-message flag.
// ---------------------------------------------------------------------------
interface crcs_msg_if;
	logic                   valid;
	logic                   ready;
	crcs_pkg::data_byte_t   data_byte;
	logic                   last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hw/rtl/crcs_crc_if.sv
// ---------------------------------------------------------------------------
// crcs_crc_if
// Result channel: one finished CRC per transaction.
// ---------------------------------------------------------------------------
interface crcs_crc_if;
	logic           valid;
	logic           ready;
	crcs_pkg::crc_t crc_value;

	modport source (output valid, output crc_value, input ready);
	modport sink   (input valid, input crc_value, output ready);
endinterface

// File: hw/rtl/crcs_cfg_if.sv
// ---------------------------------------------------------------------------
// crcs_cfg_if
// Configuration write channel for the polynomial select register.
// ---------------------------------------------------------------------------
interface crcs_cfg_if;
	logic                valid;
	logic                ready;
	crcs_pkg::poly_sel_t poly_select;

	modport source (output valid, output poly_select, input ready);
	modport sink   (input valid, input poly_select, output ready);
endinterface

// File: hw/rtl/crc32_multi_poly_stream_unit.sv
// Path: stage-1 byte register, fold, result register for a last byte's CRC.
// Throughput: one byte per cycle unless stage 1 holds a last byte and the
// result slot is busy; the eight-step remainder fold loop sets this rate.
// Reset (arst_n low, async): remainder cleared to zero, polynomial select
// to CRC-32, both channels empty.
// ---------------------------------------------------------------------------
// crc32_multi_poly_stream_unit
// Streaming MSB-first CRC-32 over bytes with a selectable fixed polynomial.
// ---------------------------------------------------------------------------
module crc32_multi_poly_stream_unit (
	input  logic      clk,
	input  logic      arst_n,
	crcs_cfg_if.sink  cfg,
	crcs_msg_if.sink  msg,
	crcs_crc_if.source crc
);
	import crcs_pkg::*;

	poly_sel_t  poly_q;

	logic       valid_s1;
	data_byte_t data_s1;
	logic       last_s1;

	crc_t       rem_q;
	crc_t       fold_s1;
	logic       adv_s1;

	logic       out_valid_q;
	crc_t       out_crc_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_CRC32;
		end else if (cfg.valid) begin
			poly_q <= cfg.poly_select;
		end
	end

	// stage 1 stalls only when it holds a last byte and the result slot is busy
	assign adv_s1 = valid_s1 && !(last_s1 && out_valid_q && !crc.ready);
	assign msg.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.ready && msg.valid) begin
			data_s1 <= msg.data_byte;
			last_s1 <= msg.last_byte;
		end
	end

	assign fold_s1 = crc_fold(rem_q, data_s1, poly_lookup(poly_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (adv_s1) begin
			rem_q <= last_s1 ? '0 : fold_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (crc.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_crc_q <= fold_s1;
		end
	end

	assign crc.valid     = out_valid_q;
	assign crc.crc_value = out_crc_q;

endmodule

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for crc32_multi_poly_stream_unit. Messages go in as byte
// transactions, with random gaps and random stalls on the result channel. The
// scoreboard folds each accepted byte with the selected polynomial and checks
// every CRC that comes out, in order.
// ---------------------------------------------------------------------------
module tb;
	import crcs_pkg::*;

	class crc_scoreboard;
		crc_t      remainder;
		poly_sel_t poly;
		crc_t      pending_crcs[$];
		int        fail_count;
		int        crc_count;

		function new();
			remainder  = '0;
			poly       = POLY_CRC32;
			fail_count = 0;
			crc_count  = 0;
		endfunction

		function void set_poly(poly_sel_t sel);
			poly = sel;
		endfunction

		function crc_t generator();
			crc_t g;
			case (poly)
				POLY_CRC32:  g = 32'h04C1_1DB7;
				POLY_CRC32C: g = 32'h1EDC_6F41;
				POLY_CRC32K: g = 32'h741B_8CD7;
				default:     g = 32'h8141_41AB;
			endcase
			return g;
		endfunction

		// MSB-first long division of one byte into the running remainder
		function void note_byte(data_byte_t data, logic last);
			crc_t g;
			g = generator();
			remainder = remainder ^ {data, 24'h0};
			for (int i = 0; i < 8; i++) begin
				if (remainder[31]) begin
					remainder = {remainder[30:0], 1'b0} ^ g;
				end else begin
					remainder = {remainder[30:0], 1'b0};
				end
			end
			if (last) begin
				pending_crcs.push_back(remainder);
				remainder = '0;
			end
		endfunction

		function void check_crc(crc_t actual);
			crc_t want;
			crc_count++;
			if (pending_crcs.size() == 0) begin
				$error("crc_value: expected none, actual %h", actual);
				fail_count++;
				return;
			end
			want = pending_crcs.pop_front();
			if (want !== actual) begin
				$error("crc_value: expected %h, actual %h", want, actual);
				fail_count++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	crcs_cfg_if cfg_bus ();
	crcs_msg_if msg_bus ();
	crcs_crc_if crc_bus ();

	crc32_multi_poly_stream_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.msg    (msg_bus),
		.crc    (crc_bus)
	);

	crc_scoreboard sb = new();
	bit            src_idles;
	bit            snk_idles;
	int            bytes_sent;
	int            cfg_writes;
	poly_sel_t     all_polys [4] = '{POLY_CRC32, POLY_CRC32C, POLY_CRC32K, POLY_CRC32Q};

	always #5 clk = ~clk;

	task automatic send_byte(input data_byte_t data, input logic last);
		int gap;
		gap = src_idles ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			msg_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_bus.valid     <= 1'b1;
		msg_bus.data_byte <= data;
		msg_bus.last_byte <= last;
		do @(posedge clk); while (msg_bus.ready !== 1'b1);
		sb.note_byte(data, last);
		bytes_sent++;
	endtask

	task automatic send_message(input int len, input bit close);
		for (int i = 0; i < len; i++) begin
			send_byte(data_byte_t'($urandom_range(0, 255)), close && (i == len - 1));
		end
	endtask

	// drop valid, drain all CRCs, then give the pipeline time to settle
	task automatic wait_idle();
		msg_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_crcs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_poly(input poly_sel_t sel);
		cfg_bus.valid       <= 1'b1;
		cfg_bus.poly_select <= sel;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		sb.set_poly(sel);
		cfg_writes++;
		cfg_bus.valid <= 1'b0;
	endtask

	// result side: random stall after each transaction while snk_idles is set
	initial begin
		int stall;
		stall = 0;
		crc_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (crc_bus.valid === 1'b1 && crc_bus.ready === 1'b1) begin
				sb.check_crc(crc_bus.crc_value);
				stall = snk_idles ? $urandom_range(0, 16) : 0;
			end else if (stall > 0) begin
				stall--;
			end
			crc_bus.ready <= (stall == 0);
		end
	end

	initial begin
		int  sent;
		int  len;
		bit  open;
		arst_n              <= 1'b0;
		msg_bus.valid       <= 1'b0;
		msg_bus.data_byte   <= '0;
		msg_bus.last_byte   <= 1'b0;
		cfg_bus.valid       <= 1'b0;
		cfg_bus.poly_select <= POLY_CRC32;
		src_idles  = 1'b0;
		snk_idles  = 1'b0;
		bytes_sent = 0;
		cfg_writes = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset polynomial: single-byte extremes, then the "123456789" check string
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'h01, 1'b1);
		for (int i = 0; i < 9; i++) begin
			send_byte(data_byte_t'(8'h31 + i), i == 8);
		end
		for (int p = 1; p < 4; p++) begin
			wait_idle();
			write_poly(all_polys[p]);
			send_byte(8'hFF, 1'b1);
			send_byte(8'hA5, 1'b0);
			send_byte(8'h5A, 1'b1);
		end
		// polynomial switch in the middle of a message
		send_byte(8'h12, 1'b0);
		wait_idle();
		write_poly(POLY_CRC32);
		send_byte(8'h34, 1'b1);

		for (int ph = 0; ph < 12; ph++) begin
			wait_idle();
			write_poly(ph < 4 ? all_polys[ph] : all_polys[$urandom_range(0, 3)]);
			src_idles = ($urandom_range(0, 2) != 0);
			snk_idles = ($urandom_range(0, 2) != 0);
			sent = 0;
			while (sent < 32) begin
				len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
				// sometimes leave the message open across the next polynomial write
				open = (sent + len >= 32) && ($urandom_range(0, 1) == 1);
				send_message(len, !open);
				sent += len;
			end
		end
		send_message($urandom_range(1, 4), 1'b1);
		wait_idle();

		if (sb.pending_crcs.size() != 0) begin
			$error("crc_value: expected %0d more, actual none", sb.pending_crcs.size());
			sb.fail_count++;
		end
		$display("Covered %0d bytes and %0d CRC transactions over all four polynomials,",
			bytes_sent, sb.crc_count);
		$display("with %0d polynomial writes, some of them mid-message.", cfg_writes);
		if (sb.fail_count == 0) begin
			$display("[crc32_multi_poly_stream_unit] OK");
		end else begin
			$display("[crc32_multi_poly_stream_unit] ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3000000;
		$display("[crc32_multi_poly_stream_unit] ERROR");
		$finish;
	end

endmodule
